>>> hw/rtl/fsa_pkg.sv
// Shared types, constants and helpers for the fixed slot allocator.
`default_nettype none
package fsa_pkg;

	localparam int SLOTS = 64;
	localparam int IDX_W = $clog2(SLOTS);
	localparam int LINK_W = $clog2(SLOTS + 1);
	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam int SLOT_W = 6;
	localparam int RIDX_W = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
	localparam int BYTES_W = 17;
	localparam int OFF_W = 22;
	localparam int PROD_W = RIDX_W + BYTES_W;
	localparam logic [BYTES_W-1:0] BYTES_RESET = BYTES_W'(64);
	localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(SLOTS);

	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE = 1'b1;

	typedef struct packed {
		logic used;
		logic [LINK_W-1:0] next;
		logic [LINK_W-1:0] prev;
	} fsa_entry_t;

	localparam int ENTRY_W = $bits(fsa_entry_t);

	typedef struct packed {
		logic rd_en;
		logic [IDX_W-1:0] rd_addr;
		logic wr_en;
		logic [IDX_W-1:0] wr_addr;
		fsa_entry_t wr_data;
	} fsa_mem_req_t;

	typedef struct packed {
		logic granted;
		logic [RIDX_W-1:0] idx;
		logic was_used;
		logic [CNT_W-1:0] count;
	} fsa_result_t;

	function automatic fsa_entry_t reset_entry(input logic [IDX_W-1:0] idx);
		fsa_entry_t e;
		e.used = 1'b0;
		e.next = LINK_W'(idx) + LINK_W'(1);
		e.prev = (idx == '0) ? LINK_NONE : (LINK_W'(idx) - LINK_W'(1));
		return e;
	endfunction

	function automatic logic [LINK_W-1:0] to_link(input logic [IDX_W-1:0] idx);
		return LINK_W'(idx);
	endfunction

endpackage
`default_nettype wire

>>> hw/rtl/fsa_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module fsa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

>>> hw/rtl/fsa_slot_store.sv
// Slot entry store: RAM plus per-entry valid bits that stand in for the reset contents.
`default_nettype none
module fsa_slot_store (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire fsa_pkg::fsa_mem_req_t req,
	output fsa_pkg::fsa_entry_t       rdata
);

	logic [fsa_pkg::SLOTS-1:0]   valid_q;
	logic [fsa_pkg::IDX_W-1:0]   rd_addr_q;
	logic [fsa_pkg::ENTRY_W-1:0] ram_rdata;

	fsa_ram #(
		.WIDTH(fsa_pkg::ENTRY_W),
		.DEPTH(fsa_pkg::SLOTS)
	) u_ram (
		.clk  (clk),
		.we   (req.wr_en),
		.waddr(req.wr_addr),
		.wdata(req.wr_data),
		.re   (req.rd_en),
		.raddr(req.rd_addr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rd_addr_q <= '0;
		end else begin
			if (req.wr_en) begin
				valid_q[req.wr_addr] <= 1'b1;
			end
			if (req.rd_en) begin
				rd_addr_q <= req.rd_addr;
			end
		end
	end

	assign rdata = valid_q[rd_addr_q] ? fsa_pkg::fsa_entry_t'(ram_rdata)
	                                  : fsa_pkg::reset_entry(rd_addr_q);

endmodule
`default_nettype wire

>>> hw/rtl/fsa_seq.sv
// Request sequencer: read-modify-write of slot entries, list head/tail and use count.
`default_nettype none
module fsa_seq (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        req_valid,
	output logic                             req_ready,
	input  wire logic                        req_kind,
	input  wire logic [fsa_pkg::SLOT_W-1:0]  req_slot,
	output fsa_pkg::fsa_mem_req_t            mem_req,
	input  wire fsa_pkg::fsa_entry_t         mem_rdata,
	output logic                             res_valid,
	input  wire logic                        res_ready,
	output fsa_pkg::fsa_result_t             res
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_A_MAIN,
		ST_A_NH,
		ST_A_TL,
		ST_F_MAIN,
		ST_F_P,
		ST_F_N,
		ST_F_H,
		ST_DONE
	} state_t;

	state_t                      state_q;
	logic [fsa_pkg::IDX_W-1:0]   head_q;
	logic [fsa_pkg::IDX_W-1:0]   tail_q;
	logic [fsa_pkg::CNT_W-1:0]   count_q;
	logic [fsa_pkg::IDX_W-1:0]   h_q;
	logic [fsa_pkg::IDX_W-1:0]   nh_q;
	logic [fsa_pkg::IDX_W-1:0]   p_q;
	logic [fsa_pkg::LINK_W-1:0]  n_q;
	fsa_pkg::fsa_result_t        res_q;

	fsa_pkg::fsa_entry_t         e;
	logic                        slot_ok;
	logic                        a_move;
	logic                        f_move;
	logic                        n_ok;
	logic                        p_is_head;
	logic [fsa_pkg::CNT_W-1:0]   cnt_free;

	assign e = mem_rdata;
	assign slot_ok = 32'(req_slot) < fsa_pkg::SLOTS;
	assign a_move = (head_q != tail_q) && (e.next < fsa_pkg::LINK_NONE);
	assign f_move = (e.prev < fsa_pkg::LINK_NONE) && (h_q != head_q);
	assign n_ok = n_q < fsa_pkg::LINK_NONE;
	assign p_is_head = p_q == head_q;
	assign cnt_free = (e.used && count_q != '0) ? count_q - fsa_pkg::CNT_W'(1) : count_q;

	always_comb begin
		mem_req = '0;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					if (req_kind == fsa_pkg::KIND_ALLOC) begin
						mem_req.rd_en = 1'b1;
						mem_req.rd_addr = head_q;
					end else if (slot_ok) begin
						mem_req.rd_en = 1'b1;
						mem_req.rd_addr = fsa_pkg::IDX_W'(req_slot);
					end
				end
			end
			ST_A_MAIN: begin
				if (!e.used) begin
					mem_req.wr_en = 1'b1;
					mem_req.wr_addr = head_q;
					if (a_move) begin
						mem_req.wr_data = '{1'b1, fsa_pkg::LINK_NONE, fsa_pkg::to_link(tail_q)};
						mem_req.rd_en = 1'b1;
						mem_req.rd_addr = e.next[fsa_pkg::IDX_W-1:0];
					end else begin
						mem_req.wr_data = '{1'b1, e.next, e.prev};
					end
				end
			end
			ST_A_NH: begin
				mem_req.wr_en = 1'b1;
				mem_req.wr_addr = nh_q;
				if (nh_q == tail_q) begin
					mem_req.wr_data = '{e.used, fsa_pkg::to_link(head_q), fsa_pkg::LINK_NONE};
				end else begin
					mem_req.wr_data = '{e.used, e.next, fsa_pkg::LINK_NONE};
					mem_req.rd_en = 1'b1;
					mem_req.rd_addr = tail_q;
				end
			end
			ST_A_TL: begin
				mem_req.wr_en = 1'b1;
				mem_req.wr_addr = tail_q;
				mem_req.wr_data = '{e.used, fsa_pkg::to_link(head_q), e.prev};
			end
			ST_F_MAIN: begin
				mem_req.wr_en = 1'b1;
				mem_req.wr_addr = h_q;
				if (f_move) begin
					mem_req.wr_data = '{1'b0, fsa_pkg::to_link(head_q), fsa_pkg::LINK_NONE};
					mem_req.rd_en = 1'b1;
					mem_req.rd_addr = e.prev[fsa_pkg::IDX_W-1:0];
				end else begin
					mem_req.wr_data = '{1'b0, e.next, e.prev};
				end
			end
			ST_F_P: begin
				mem_req.wr_en = 1'b1;
				mem_req.wr_addr = p_q;
				mem_req.wr_data = '{e.used, n_q, p_is_head ? fsa_pkg::to_link(h_q) : e.prev};
				if (n_ok) begin
					mem_req.rd_en = 1'b1;
					mem_req.rd_addr = n_q[fsa_pkg::IDX_W-1:0];
				end else if (!p_is_head) begin
					mem_req.rd_en = 1'b1;
					mem_req.rd_addr = head_q;
				end
			end
			ST_F_N: begin
				mem_req.wr_en = 1'b1;
				mem_req.wr_addr = n_q[fsa_pkg::IDX_W-1:0];
				mem_req.wr_data = '{e.used, e.next, fsa_pkg::to_link(p_q)};
				if (!p_is_head) begin
					mem_req.rd_en = 1'b1;
					mem_req.rd_addr = head_q;
				end
			end
			ST_F_H: begin
				mem_req.wr_en = 1'b1;
				mem_req.wr_addr = head_q;
				mem_req.wr_data = '{e.used, e.next, fsa_pkg::to_link(h_q)};
			end
			default: begin
				mem_req = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q <= '0;
			tail_q <= fsa_pkg::IDX_W'(fsa_pkg::SLOTS - 1);
			count_q <= '0;
			h_q <= '0;
			nh_q <= '0;
			p_q <= '0;
			n_q <= '0;
			res_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						if (req_kind == fsa_pkg::KIND_ALLOC) begin
							h_q <= head_q;
							state_q <= ST_A_MAIN;
						end else if (slot_ok) begin
							h_q <= fsa_pkg::IDX_W'(req_slot);
							state_q <= ST_F_MAIN;
						end else begin
							res_q <= '{1'b0, fsa_pkg::RIDX_W'(req_slot), 1'b0, count_q};
							state_q <= ST_DONE;
						end
					end
				end
				ST_A_MAIN: begin
					if (e.used) begin
						res_q <= '{1'b0, '0, 1'b0, count_q};
						state_q <= ST_DONE;
					end else begin
						count_q <= count_q + fsa_pkg::CNT_W'(1);
						res_q <= '{1'b1, fsa_pkg::RIDX_W'(head_q), 1'b0,
						           count_q + fsa_pkg::CNT_W'(1)};
						if (a_move) begin
							nh_q <= e.next[fsa_pkg::IDX_W-1:0];
							state_q <= ST_A_NH;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_A_NH: begin
					if (nh_q == tail_q) begin
						head_q <= nh_q;
						tail_q <= head_q;
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_A_TL;
					end
				end
				ST_A_TL: begin
					head_q <= nh_q;
					tail_q <= head_q;
					state_q <= ST_DONE;
				end
				ST_F_MAIN: begin
					count_q <= cnt_free;
					res_q <= '{1'b0, fsa_pkg::RIDX_W'(h_q), e.used, cnt_free};
					if (f_move) begin
						p_q <= e.prev[fsa_pkg::IDX_W-1:0];
						n_q <= e.next;
						state_q <= ST_F_P;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_F_P: begin
					if (!n_ok) begin
						tail_q <= p_q;
					end
					if (n_ok) begin
						state_q <= ST_F_N;
					end else if (!p_is_head) begin
						state_q <= ST_F_H;
					end else begin
						head_q <= h_q;
						state_q <= ST_DONE;
					end
				end
				ST_F_N: begin
					if (!p_is_head) begin
						state_q <= ST_F_H;
					end else begin
						head_q <= h_q;
						state_q <= ST_DONE;
					end
				end
				ST_F_H: begin
					head_q <= h_q;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign req_ready = state_q == ST_IDLE;
	assign res_valid = state_q == ST_DONE;
	assign res = res_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= fsa_pkg::SLOTS)
		else $error("use count above pool size");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		mem_req.wr_en && mem_req.rd_en |-> mem_req.wr_addr != mem_req.rd_addr)
		else $error("read and write of one entry in the same cycle");

	a_grant_count: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_q.granted |-> res_q.count != '0 && !res_q.was_used)
		else $error("grant with zero use count or used mark");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_q))
		else $error("pending result changed while stalled");

endmodule
`default_nettype wire

>>> hw/rtl/fixed_slot_allocator_unit.sv
// Top level of the fixed slot allocator: stream ports, slot size register, output stage.
//
// channel  dir  handshake                    payload
// s_axis   in   s_axis_tvalid/s_axis_tready  tdata: slot; tuser: kind
// m_axis   out  m_axis_tvalid/m_axis_tready  tdata: slot_index, byte_offset, used_count;
//                                            tuser: granted, was_used
// cfg      in   cfg_wr_en                    cfg_wr_data: slot_bytes
//
// One item at a time through the entry RAM, one read-modify-write per cycle:
// alloc reads the head, and a tail move also rewrites the new head and old tail; free
// rewrites the slot, a head move also its neighbours and old head; out-of-range: none.
// Reset is immediate: per-entry valid bits stand in for the initial link contents.
// The next item is accepted while a result waits in the output register.
`default_nettype none
module fixed_slot_allocator_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,  // [5:0] slot
	input  wire logic [0:0]  s_axis_tuser,  // [0] kind
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic      [39:0] m_axis_tdata,  // [5:0] slot_index, [27:6] byte_offset,
	                                        // [34:28] used_count
	output logic      [1:0]  m_axis_tuser,  // [0] granted, [1] was_used
	input  wire logic        cfg_wr_en,
	input  wire logic [16:0] cfg_wr_data
);

	logic [fsa_pkg::BYTES_W-1:0] slot_bytes_q;
	fsa_pkg::fsa_mem_req_t       mem_req;
	fsa_pkg::fsa_entry_t         mem_rdata;
	logic                        res_valid;
	logic                        res_ready;
	fsa_pkg::fsa_result_t        res;
	logic [fsa_pkg::PROD_W-1:0]  prod;

	logic                        out_valid_q;
	logic                        out_granted_q;
	logic [fsa_pkg::SLOT_W-1:0]  out_idx_q;
	logic [fsa_pkg::OFF_W-1:0]   out_off_q;
	logic                        out_was_q;
	logic [6:0]                  out_cnt_q;

	fsa_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(s_axis_tvalid),
		.req_ready(s_axis_tready),
		.req_kind (s_axis_tuser[0]),
		.req_slot (s_axis_tdata[fsa_pkg::SLOT_W-1:0]),
		.mem_req  (mem_req),
		.mem_rdata(mem_rdata),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

	fsa_slot_store u_store (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (mem_req),
		.rdata (mem_rdata)
	);

	assign res_ready = !out_valid_q || m_axis_tready;
	assign prod = fsa_pkg::PROD_W'(res.idx) * fsa_pkg::PROD_W'(slot_bytes_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_bytes_q <= fsa_pkg::BYTES_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				slot_bytes_q <= cfg_wr_data;
			end
			if (res_valid && res_ready) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_granted_q <= res.granted;
			out_idx_q <= res.idx[fsa_pkg::SLOT_W-1:0];
			out_off_q <= prod[fsa_pkg::OFF_W-1:0];
			out_was_q <= res.was_used;
			out_cnt_q <= 7'(res.count);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {5'b0, out_cnt_q, out_off_q, out_idx_q};
	assign m_axis_tuser = {out_was_q, out_granted_q};

endmodule
`default_nettype wire

>>> verif/tb_fixed_slot_allocator_unit.sv
// Testbench for the fixed slot allocator: random requests with stalls, checked against a predictor.
`timescale 1ns / 1ps
module tb_fixed_slot_allocator_unit;
	import fsa_pkg::*;

	localparam int IDLE_LIMIT = 2000;

	typedef struct {
		logic kind;
		logic [5:0] slot;
		int unsigned gap;
	} slot_request_t;

	typedef struct packed {
		logic granted;
		logic [5:0] idx;
		logic [OFF_W-1:0] offset;
		logic was_used;
		logic [6:0] count;
	} slot_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [7:0] s_axis_tdata = '0;
	logic [0:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;
	logic [1:0] m_axis_tuser;
	logic cfg_wr_en = 1'b0;
	logic [16:0] cfg_wr_data = '0;

	fixed_slot_allocator_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// allocator shadow state
	logic slot_used[SLOTS];
	logic [LINK_W-1:0] next_slot[SLOTS];
	logic [LINK_W-1:0] prev_slot[SLOTS];
	logic [LINK_W-1:0] order_head;
	logic [LINK_W-1:0] order_tail;
	logic [6:0] used_total;
	logic [BYTES_W-1:0] slot_size;

	slot_request_t pending_requests[$];
	slot_result_t expected_results[$];
	int errors = 0;
	bit tx_calm = 1'b0;
	int unsigned tx_queued = 0;

	function automatic slot_result_t make_result(input logic granted, input logic [5:0] idx,
			input logic was_used);
		slot_result_t r;
		logic [PROD_W-1:0] prod;
		prod = idx * slot_size;
		r.granted = granted;
		r.idx = idx;
		r.offset = prod[OFF_W-1:0];
		r.was_used = was_used;
		r.count = used_total;
		return r;
	endfunction

	task automatic apply_request(input logic kind, input logic [5:0] slot);
		logic [LINK_W-1:0] h;
		logic [LINK_W-1:0] nh;
		logic [LINK_W-1:0] p;
		logic [LINK_W-1:0] n;
		logic was;
		if (kind == KIND_ALLOC) begin
			h = order_head;
			if (h >= SLOTS || slot_used[h[IDX_W-1:0]]) begin
				expected_results.push_back(make_result(1'b0, 6'd0, 1'b0));
			end else begin
				slot_used[h[IDX_W-1:0]] = 1'b1;
				used_total++;
				nh = next_slot[h[IDX_W-1:0]];
				if (h != order_tail && nh < SLOTS && order_tail < SLOTS) begin
					prev_slot[nh[IDX_W-1:0]] = LINK_NONE;
					next_slot[order_tail[IDX_W-1:0]] = h;
					prev_slot[h[IDX_W-1:0]] = order_tail;
					next_slot[h[IDX_W-1:0]] = LINK_NONE;
					order_tail = h;
					order_head = nh;
				end
				expected_results.push_back(make_result(1'b1, h[5:0], 1'b0));
			end
		end else begin
			was = slot_used[slot];
			if (was && used_total > 0)
				used_total--;
			slot_used[slot] = 1'b0;
			p = prev_slot[slot];
			if (p < SLOTS && LINK_W'(slot) != order_head) begin
				n = next_slot[slot];
				if (n >= SLOTS) begin
					next_slot[p[IDX_W-1:0]] = LINK_NONE;
					order_tail = p;
				end else begin
					next_slot[p[IDX_W-1:0]] = n;
					prev_slot[n[IDX_W-1:0]] = p;
				end
				prev_slot[slot] = LINK_NONE;
				next_slot[slot] = order_head;
				if (order_head < SLOTS)
					prev_slot[order_head[IDX_W-1:0]] = LINK_W'(slot);
				order_head = LINK_W'(slot);
			end
			expected_results.push_back(make_result(1'b0, slot, was));
		end
	endtask

	task automatic check_field(input string what, input int unsigned want, input int unsigned got);
		if (want != got) begin
			errors++;
			$display("%0t mismatch %s: expected %0d actual %0d", $time, what, want, got);
		end
	endtask

	task automatic queue_request(input logic kind, input logic [5:0] slot);
		slot_request_t r;
		if (tx_queued % 40 == 0)
			tx_calm = ($urandom_range(0, 2) == 0);
		tx_queued++;
		r.kind = kind;
		r.slot = slot;
		r.gap = tx_calm ? 0 : $urandom_range(0, 15);
		pending_requests.push_back(r);
	endtask

	task automatic queue_random_requests(input int count, input int alloc_pct);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 99) < alloc_pct)
				queue_request(KIND_ALLOC, 6'($urandom_range(0, 63)));
			else
				queue_request(KIND_FREE, 6'($urandom_range(0, 63)));
		end
	endtask

	task automatic wait_for_idle();
		while (pending_requests.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_slot_size(input logic [16:0] value);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		slot_size = value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// sender
	int unsigned tx_waited = 0;

	always @(posedge clk or negedge arst_n) begin
		slot_request_t item;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				apply_request(s_axis_tuser[0], s_axis_tdata[5:0]);
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_requests.size() == 0) begin
					s_axis_tvalid <= 1'b0;
				end else if (tx_waited < pending_requests[0].gap) begin
					tx_waited++;
					s_axis_tvalid <= 1'b0;
				end else begin
					item = pending_requests.pop_front();
					tx_waited = 0;
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {2'b00, item.slot};
					s_axis_tuser <= item.kind;
				end
			end
		end
	end

	// receiver and checker
	int unsigned results_seen = 0;
	int unsigned rx_wait = 0;
	int unsigned rx_waited = 0;
	int unsigned rx_hold = 0;
	bit rx_calm = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		slot_result_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_results.size() == 0) begin
					errors++;
					$display("%0t unexpected result: expected none actual %h/%h", $time,
						m_axis_tuser, m_axis_tdata);
				end else begin
					want = expected_results.pop_front();
					check_field("granted", want.granted, m_axis_tuser[0]);
					check_field("slot_index", want.idx, m_axis_tdata[5:0]);
					check_field("byte_offset", want.offset, m_axis_tdata[27:6]);
					check_field("was_used", want.was_used, m_axis_tuser[1]);
					check_field("used_count", want.count, m_axis_tdata[34:28]);
				end
				results_seen++;
				if (results_seen % 64 == 0)
					rx_calm = ($urandom_range(0, 2) == 0);
				rx_wait = rx_calm ? 0 : $urandom_range(0, 15);
				rx_waited = 0;
				// long back-pressure so the input side fills and stalls
				if (results_seen == 300)
					rx_hold = 250;
			end
			if (rx_hold > 0) begin
				rx_hold--;
				m_axis_tready <= 1'b0;
			end else if (rx_waited < rx_wait) begin
				rx_waited++;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// watchdog
	int unsigned idle_cycles = 0;
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	logic [16:0] size_plan[7];
	int alloc_plan[7];

	initial begin
		for (int i = 0; i < SLOTS; i++) begin
			slot_used[i] = 1'b0;
			next_slot[i] = LINK_W'(i + 1);
			prev_slot[i] = (i == 0) ? LINK_NONE : LINK_W'(i - 1);
		end
		order_head = '0;
		order_tail = LINK_W'(SLOTS - 1);
		used_total = '0;
		slot_size = BYTES_RESET;

		size_plan = '{17'd1, 17'h10000, 17'h1FFFF, 17'd0, 17'($urandom_range(1, 65536)),
			17'($urandom_range(1, 65536)), 17'd3};
		alloc_plan = '{30, 95, 50, 70, 20, 85, 50};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed: tail and head moves, double free, free of head, refill
		queue_request(KIND_FREE, 6'd63);
		queue_request(KIND_FREE, 6'd0);
		queue_request(KIND_ALLOC, 6'd63);
		queue_request(KIND_ALLOC, 6'd0);
		queue_request(KIND_ALLOC, 6'd42);
		queue_request(KIND_FREE, 6'd63);
		queue_request(KIND_FREE, 6'd63);
		queue_request(KIND_FREE, 6'd1);
		queue_request(KIND_ALLOC, 6'd0);
		queue_request(KIND_ALLOC, 6'd0);
		queue_request(KIND_FREE, 6'd0);
		queue_request(KIND_ALLOC, 6'd21);
		queue_request(KIND_ALLOC, 6'd0);
		queue_request(KIND_ALLOC, 6'd0);
		queue_random_requests(180, 90);
		wait_for_idle();

		for (int ph = 0; ph < 7; ph++) begin
			write_slot_size(size_plan[ph]);
			queue_random_requests(180, alloc_plan[ph]);
			wait_for_idle();
		end

		repeat (12) @(negedge clk);
		errors += expected_results.size();
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
